// ===== src/double_ended_queue_unit_assert.svh =====
// assertion macros for the double-ended queue unit
// no dependencies; included by the controller and datapath modules
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// checked only outside reset
`define DEQU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DEQU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dequ_pkg.sv =====
// shared types and codes for the double-ended queue unit
// no dependencies
`timescale 1ns / 1ps

package dequ_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_DUMP       = 3'd4
   } dequ_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_EMPTY = 2'd3
   } dequ_status_type;

   typedef struct packed {
      logic            push_front;
      logic            push_rear;
      logic            pop_front;
      logic            pop_rear;
      logic            dump_start;
      logic            dump_next;
      logic            take_mem;
      logic            imm_load;
      dequ_status_type imm_status;
   } dequ_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_last;
   } dequ_stat_type;

endpackage

// ===== src/dequ_dpath.sv =====
// datapath: slot memory, front index, occupancy, dump walker and result register
// depends on dequ_pkg and double_ended_queue_unit_assert.svh
`timescale 1ns / 1ps
`include "double_ended_queue_unit_assert.svh"

module dequ_dpath
   import dequ_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dequ_cmd_type        cmd,
   input  logic [WORD_W-1:0]   push_value,
   output dequ_stat_type       stat,
   output logic [WORD_W-1:0]   out_value,
   output dequ_status_type     out_status,
   output logic                out_last
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = IDX_W + 1;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              last_pend_ff, last_pend_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] out_value_ff, out_value_in;
   dequ_status_type   out_status_ff, out_status_in;
   logic              out_last_ff, out_last_in;

   logic [IDX_W-1:0]  front_dec;
   logic [IDX_W-1:0]  front_inc;
   logic [IDX_W-1:0]  rear_next;
   logic [IDX_W-1:0]  rear_last;
   logic [IDX_W-1:0]  pos_inc;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic              rd_en;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return r[IDX_W-1:0];
   endfunction

   always_comb begin
      front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
      front_inc = wrap_idx(SUM_W'(front_ff) + SUM_W'(1));
      rear_next = wrap_idx(SUM_W'(front_ff) + SUM_W'(count_ff));
      rear_last = wrap_idx(SUM_W'(front_ff) + SUM_W'(count_ff) - SUM_W'(1));
      pos_inc   = wrap_idx(SUM_W'(pos_ff) + SUM_W'(1));
   end

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      last_pend_in  = last_pend_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = rear_next;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      if (cmd.push_front) begin
         wr_en    = 1'b1;
         wr_addr  = front_dec;
         front_in = front_dec;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.push_rear) begin
         wr_en    = 1'b1;
         wr_addr  = rear_next;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop_front) begin
         rd_en        = 1'b1;
         rd_addr      = front_ff;
         front_in     = front_inc;
         count_in     = count_ff - CNT_W'(1);
         last_pend_in = 1'b1;
      end
      if (cmd.pop_rear) begin
         rd_en        = 1'b1;
         rd_addr      = rear_last;
         count_in     = count_ff - CNT_W'(1);
         last_pend_in = 1'b1;
      end
      if (cmd.dump_start) begin
         rd_en        = 1'b1;
         rd_addr      = front_ff;
         pos_in       = front_inc;
         rem_in       = count_ff;
         last_pend_in = (count_ff == CNT_W'(1));
      end
      if (cmd.dump_next) begin
         rd_en        = 1'b1;
         rd_addr      = pos_ff;
         pos_in       = pos_inc;
         rem_in       = rem_ff - CNT_W'(1);
         last_pend_in = (rem_ff == CNT_W'(2));
      end
      if (cmd.imm_load) begin
         out_value_in  = '0;
         out_status_in = cmd.imm_status;
         out_last_in   = 1'b1;
      end
      if (cmd.take_mem) begin
         out_value_in  = rd_data_ff;
         out_status_in = ST_OK;
         out_last_in   = last_pend_ff;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      last_pend_ff  <= last_pend_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.out_last = out_last_ff;
   assign out_value     = out_value_ff;
   assign out_status    = out_status_ff;
   assign out_last      = out_last_ff;

   `DEQU_ASSERT_ALWAYS(a_count_bound, clock,
      reset || (count_ff <= CNT_W'(DEPTH)), "occupancy above depth")
   `DEQU_ASSERT(a_no_push_full, clock, reset,
      (cmd.push_front || cmd.push_rear) |-> !stat.full, "push into full queue")
   `DEQU_ASSERT(a_no_pop_empty, clock, reset,
      (cmd.pop_front || cmd.pop_rear || cmd.dump_start) |-> !stat.empty, "read from empty queue")
   `DEQU_ASSERT(a_push_count, clock, reset,
      (cmd.push_front || cmd.push_rear) |=> count_ff == $past(count_ff) + CNT_W'(1),
      "push did not grow occupancy")

endmodule

// ===== src/dequ_ctrl.sv =====
// controller state machine: accepts items, issues datapath commands, paces results
// depends on dequ_pkg and double_ended_queue_unit_assert.svh
`timescale 1ns / 1ps
`include "double_ended_queue_unit_assert.svh"

module dequ_ctrl
   import dequ_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [OP_W-1:0] req_op,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dequ_stat_type stat,
   output dequ_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SEND = 3'b100
   } dequ_state_type;

   dequ_state_type state_ff, state_in;
   logic           accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_PUSH_FRONT: begin
                     cmd.imm_load   = 1'b1;
                     cmd.imm_status = stat.full ? ST_OVER : ST_OK;
                     cmd.push_front = !stat.full;
                     state_in       = S_SEND;
                  end
                  OP_PUSH_REAR: begin
                     cmd.imm_load   = 1'b1;
                     cmd.imm_status = stat.full ? ST_OVER : ST_OK;
                     cmd.push_rear  = !stat.full;
                     state_in       = S_SEND;
                  end
                  OP_POP_FRONT, OP_POP_REAR: begin
                     if (stat.empty) begin
                        cmd.imm_load   = 1'b1;
                        cmd.imm_status = ST_UNDER;
                        state_in       = S_SEND;
                     end else begin
                        cmd.pop_front = (req_op == OP_POP_FRONT);
                        cmd.pop_rear  = (req_op == OP_POP_REAR);
                        state_in      = S_READ;
                     end
                  end
                  OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.imm_load   = 1'b1;
                        cmd.imm_status = ST_EMPTY;
                        state_in       = S_SEND;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.take_mem = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_tready) begin
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.dump_next = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DEQU_ASSERT(a_read_then_send, clock, reset, (state_ff == S_READ) |=> (state_ff == S_SEND), "read not followed by result")
   `DEQU_ASSERT(a_one_side, clock, reset, !(req_tready && rsp_tvalid), "input taken while result pending")
   `DEQU_ASSERT(a_bad_op_idle, clock, reset, (accept && req_op > OP_W'(OP_DUMP)) |=> (state_ff == S_IDLE), "unused opcode produced work")

endmodule

// ===== src/double_ended_queue_unit.sv =====
// Double-ended queue of signed 32-bit words in a circular buffer of DEPTH slots.
// Opcode in req_tuser: push front, push rear, pop front, pop rear, dump; codes 5..7
// are dropped without a result. A push, or a pop or dump on an empty queue, loads
// the result register straight from the accept; a pop reads the slot memory,
// whose read data is registered, and then loads the result register; a dump does
// that for each stored word in turn, reading the next only once the last is taken.
// The one result register holds each item until taken, which keeps the input
// closed meanwhile, so a new item is not accepted before the last result is taken.
// Reset clears front index and occupancy; slot contents need no clearing.
// depends on dequ_pkg, dequ_ctrl and dequ_dpath
`timescale 1ns / 1ps

module double_ended_queue_unit
   import dequ_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   dequ_cmd_type    cmd;
   dequ_stat_type   stat;
   dequ_status_type out_status;

   dequ_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dequ_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_tdata),
      .stat       (stat),
      .out_value  (rsp_tdata),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = out_status;

endmodule
